// ===== sv/fixed_schema_varint_message_parser_core_macros.svh =====
`ifndef FIXED_SCHEMA_VARINT_MESSAGE_PARSER_CORE_MACROS_SVH
`define FIXED_SCHEMA_VARINT_MESSAGE_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FSVMP_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("parser port check failed");

// next-cycle implication, disabled during reset
`define FSVMP_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("parser port check failed");

`endif

// ===== sv/fsvmp_pkg.sv =====
package fsvmp_pkg;

  localparam int unsigned PAYLOAD_MAX_DEFAULT = 256;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic        has_pay;
    logic [7:0]  pay_byte;
    logic [7:0]  pay_index;
    logic        has_sum;
    logic [31:0] origin_node;
    logic [31:0] message_number;
    logic [31:0] sender_node;
    logic [63:0] time_stamp;
    logic [31:0] message_kind;
    logic [31:0] hop_limit;
    logic [8:0]  payload_length;
    logic        ok;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// ===== sv/fixed_schema_varint_message_parser_core.sv =====
// Path: a byte is written into the queue, then loaded into the output register; a last byte
// that is also a payload byte yields its payload result first and then its summary result.
// Throughput: 1 byte per cycle while the queue is not full; the output register emits 1
// result per cycle while result_ready is high (the queue absorbs the extra summary result).
// Reset: synchronous; clears parser state, stored fields, queue and output valid.
module fixed_schema_varint_message_parser_core import fsvmp_pkg::*; #(
  parameter int unsigned PAYLOAD_MAX = PAYLOAD_MAX_DEFAULT,
  parameter int unsigned DEPTH       = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic [31:0] origin_node,
  output logic [31:0] message_number,
  output logic [31:0] sender_node,
  output logic [63:0] time_stamp,
  output logic [31:0] message_kind,
  output logic [31:0] hop_limit,
  output logic [8:0]  payload_length,
  output logic        ok
);

  logic   fire;
  logic   push;
  logic   full;
  logic   pop;
  entry_t push_entry;
  head_t  head;

  assign data_ready = !full;
  assign fire       = data_valid && data_ready;

  fsvmp_front #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push),
    .push_entry(push_entry)
  );

  fsvmp_queue #(
    .DEPTH(DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (full),
    .head      (head),
    .pop       (pop)
  );

  fsvmp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .origin_node   (origin_node),
    .message_number(message_number),
    .sender_node   (sender_node),
    .time_stamp    (time_stamp),
    .message_kind  (message_kind),
    .hop_limit     (hop_limit),
    .payload_length(payload_length),
    .ok            (ok)
  );

endmodule

// ===== sv/fsvmp_front.sv =====
module fsvmp_front import fsvmp_pkg::*; #(
  parameter int unsigned PAYLOAD_MAX = PAYLOAD_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       push,
  output entry_t     push_entry
);

  localparam logic [2:0] PH_KEY     = 3'd0;
  localparam logic [2:0] PH_VALUE   = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_LEN    = 3'd2;

  localparam logic [2:0] FIELD_SKIP    = 3'd0;
  localparam logic [2:0] FIELD_FIRST   = 3'd1;
  localparam logic [2:0] FIELD_LAST    = 3'd6;
  localparam logic [2:0] FIELD_PAYLOAD = 3'd7;

  localparam logic [3:0] GRP_SAT = 4'd10;

  logic [2:0]  phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  grp, grp_next;
  logic [2:0]  cur, cur_next;
  logic [63:0] btt, btt_next;
  logic [63:0] fs [6];
  logic [63:0] fs_next [6];
  logic [8:0]  len, len_next;
  logic [7:0]  pos, pos_next;
  logic        err, err_next;

  logic [6:0]  shamt;
  logic [63:0] ins;
  logic [63:0] v;
  logic        done;
  logic [31:0] fn;
  logic [2:0]  wt;
  logic        emit_pay;

  assign shamt = 7'(grp) * 7'd7;
  assign ins   = (grp < GRP_SAT) ? (64'(data_byte[6:0]) << shamt) : 64'd0;
  assign v     = acc | ins;
  assign done  = !data_byte[7];
  assign fn    = v[34:3];
  assign wt    = v[2:0];

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    grp_next   = grp;
    cur_next   = cur;
    btt_next   = btt;
    fs_next    = fs;
    len_next   = len;
    pos_next   = pos;
    err_next   = err;
    emit_pay   = 1'b0;
    if (!err && (phase == PH_KEY || phase == PH_VALUE || phase == PH_LENGTH)) begin
      acc_next = done ? 64'd0 : v;
      grp_next = done ? 4'd0 : ((grp == GRP_SAT) ? GRP_SAT : grp + 4'd1);
    end
    if (!err) begin
      case (phase)
        PH_KEY: begin
          if (done) begin
            if (fn >= 32'(FIELD_FIRST) && fn <= 32'(FIELD_LAST)) begin
              if (wt == WT_VARINT) begin
                cur_next   = fn[2:0];
                phase_next = PH_VALUE;
              end
            end else if (fn == 32'(FIELD_PAYLOAD)) begin
              if (wt == WT_LEN) begin
                cur_next   = FIELD_PAYLOAD;
                phase_next = PH_LENGTH;
              end
            end else if (wt == WT_VARINT) begin
              cur_next   = FIELD_SKIP;
              phase_next = PH_VALUE;
            end else if (wt == WT_LEN) begin
              cur_next   = FIELD_SKIP;
              phase_next = PH_LENGTH;
            end
          end
        end
        PH_VALUE: begin
          if (done) begin
            if (cur >= FIELD_FIRST && cur <= FIELD_LAST) begin
              fs_next[cur - 3'd1] = v;
            end
            phase_next = PH_KEY;
          end
        end
        PH_LENGTH: begin
          if (done) begin
            if (cur == FIELD_PAYLOAD) begin
              if (v > 64'(PAYLOAD_MAX)) begin
                err_next = 1'b1;
              end else begin
                len_next   = v[8:0];
                pos_next   = 8'd0;
                btt_next   = v;
                phase_next = (v != 64'd0) ? PH_PAYLOAD : PH_KEY;
              end
            end else begin
              btt_next   = v;
              phase_next = (v != 64'd0) ? PH_SKIP : PH_KEY;
            end
          end
        end
        PH_PAYLOAD: begin
          emit_pay = 1'b1;
          pos_next = pos + 8'd1;
          btt_next = btt - 64'd1;
          if (btt == 64'd1) begin
            phase_next = PH_KEY;
          end
        end
        PH_SKIP: begin
          btt_next = btt - 64'd1;
          if (btt == 64'd1) begin
            phase_next = PH_KEY;
          end
        end
        default: begin
          err_next = 1'b1;
        end
      endcase
    end
  end

  assign push = fire && (emit_pay || last_byte);

  always_comb begin
    push_entry                = '0;
    push_entry.has_pay        = emit_pay;
    push_entry.pay_byte       = data_byte;
    push_entry.pay_index      = pos;
    push_entry.has_sum        = last_byte;
    push_entry.origin_node    = fs_next[0][31:0];
    push_entry.message_number = fs_next[1][31:0];
    push_entry.sender_node    = fs_next[2][31:0];
    push_entry.time_stamp     = fs_next[3];
    push_entry.message_kind   = fs_next[4][31:0];
    push_entry.hop_limit      = fs_next[5][31:0];
    push_entry.payload_length = len_next;
    push_entry.ok             = !err_next && (phase_next == PH_KEY);
  end

  // the last byte returns the parser to its reset state
  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      phase <= PH_KEY;
      acc   <= 64'd0;
      grp   <= 4'd0;
      cur   <= FIELD_SKIP;
      btt   <= 64'd0;
      for (int i = 0; i < 6; i++) begin
        fs[i] <= 64'd0;
      end
      len   <= 9'd0;
      pos   <= 8'd0;
      err   <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      acc   <= acc_next;
      grp   <= grp_next;
      cur   <= cur_next;
      btt   <= btt_next;
      fs    <= fs_next;
      len   <= len_next;
      pos   <= pos_next;
      err   <= err_next;
    end
  end

endmodule

// ===== sv/fsvmp_queue.sv =====
module fsvmp_queue import fsvmp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  output head_t  head,
  input  logic   pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/fsvmp_back.sv =====
module fsvmp_back import fsvmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  head_t       head,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic [31:0] origin_node,
  output logic [31:0] message_number,
  output logic [31:0] sender_node,
  output logic [63:0] time_stamp,
  output logic [31:0] message_kind,
  output logic [31:0] hop_limit,
  output logic [8:0]  payload_length,
  output logic        ok
);

  logic load;
  logic pay_done;
  logic split_pay;

  assign load      = !result_valid || result_ready;
  assign split_pay = head.entry.has_pay && !pay_done;
  // a word carrying both results stays at the head until its summary goes out
  assign pop       = load && head.valid && !(split_pay && head.entry.has_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pay_done     <= 1'b0;
    end else if (load) begin
      result_valid <= head.valid;
      if (head.valid) begin
        pay_done <= split_pay && head.entry.has_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      if (split_pay) begin
        result_kind    <= 1'b0;
        payload_byte   <= head.entry.pay_byte;
        payload_index  <= head.entry.pay_index;
        origin_node    <= 32'd0;
        message_number <= 32'd0;
        sender_node    <= 32'd0;
        time_stamp     <= 64'd0;
        message_kind   <= 32'd0;
        hop_limit      <= 32'd0;
        payload_length <= 9'd0;
        ok             <= 1'b0;
      end else begin
        result_kind    <= 1'b1;
        payload_byte   <= 8'd0;
        payload_index  <= 8'd0;
        origin_node    <= head.entry.origin_node;
        message_number <= head.entry.message_number;
        sender_node    <= head.entry.sender_node;
        time_stamp     <= head.entry.time_stamp;
        message_kind   <= head.entry.message_kind;
        hop_limit      <= head.entry.hop_limit;
        payload_length <= head.entry.payload_length;
        ok             <= head.entry.ok;
      end
    end
  end

endmodule

// ===== sv/fsvmp_checker.sv =====
`include "fixed_schema_varint_message_parser_core_macros.svh"

module fsvmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        data_valid,
  input logic        data_ready,
  input logic [7:0]  data_byte,
  input logic        last_byte,
  input logic        result_valid,
  input logic        result_ready,
  input logic        result_kind,
  input logic [7:0]  payload_byte,
  input logic [7:0]  payload_index,
  input logic [31:0] origin_node,
  input logic [31:0] message_number,
  input logic [31:0] sender_node,
  input logic [63:0] time_stamp,
  input logic [31:0] message_kind,
  input logic [31:0] hop_limit,
  input logic [8:0]  payload_length,
  input logic        ok
);

  `FSVMP_ASSERT_NXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result_kind) && $stable(payload_byte) && $stable(payload_index) && $stable(time_stamp) && $stable(ok))

  `FSVMP_ASSERT_IMP(a_no_result_after_reset, clk, rst, $past(rst), !result_valid)

  `FSVMP_ASSERT_IMP(a_payload_word_clean, clk, rst, result_valid && !result_kind, origin_node == 32'd0 && message_number == 32'd0 && sender_node == 32'd0 && time_stamp == 64'd0 && message_kind == 32'd0 && hop_limit == 32'd0 && payload_length == 9'd0 && !ok)

  `FSVMP_ASSERT_IMP(a_summary_word_clean, clk, rst, result_valid && result_kind, payload_byte == 8'd0 && payload_index == 8'd0)

endmodule

bind fixed_schema_varint_message_parser_core fsvmp_checker u_fsvmp_checker (.*);
